### rtl/krwl_pkg.sv
// shared types and constants of the keyed reader/writer lock table
package krwl_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned COUNT_BITS = 15;
  localparam int unsigned KEY_BITS   = 48;
  localparam int unsigned IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_UNLOCK = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_BUSY = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] mode;
    key_t       key;
  } req_t;

  typedef struct packed {
    status_e status;
    logic    still_used;
  } rsp_t;

  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic free_ok;
    idx_t free_idx;
  } match_t;

endpackage

### rtl/krwl_if.sv
// request and response channel interfaces of the lock table
interface krwl_req_if import krwl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  key_t       key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface krwl_rsp_if import krwl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       still_used;

  modport source (output valid, output status, output still_used, input ready);
  modport sink (input valid, input status, input still_used, output ready);
endinterface

### rtl/krwl_match.sv
// parallel key match and first free entry search over the table
module krwl_match import krwl_pkg::*; (
  input  key_t   keys_i [ENTRIES],
  input  key_t   key_i,
  output match_t match_o
);

  always_comb begin
    match_o = '0;
    // walk downwards so the lowest index wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (keys_i[i] == key_i) begin
        match_o.hit     = 1'b1;
        match_o.hit_idx = idx_t'(i);
      end
      if (keys_i[i] == '0) begin
        match_o.free_ok  = 1'b1;
        match_o.free_idx = idx_t'(i);
      end
    end
  end

endmodule

### rtl/krwl_table.sv
// lock entry storage with the lookup and single entry update
module krwl_table import krwl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic upd_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  key_t   key_q [ENTRIES];
  logic   wh_q  [ENTRIES];
  logic   rh_q  [ENTRIES];
  count_t rc_q  [ENTRIES];
  count_t wc_q  [ENTRIES];

  match_t mt;
  idx_t   sel;
  logic   found, bad, busy, used, we;
  logic   wh, rh, wh_d, rh_d;
  count_t rc, wc, rc_d, wc_d;
  key_t   key_d;

  krwl_match u_match (
    .keys_i  (key_q),
    .key_i   (req_i.key),
    .match_o (mt)
  );

  always_comb begin
    sel   = mt.hit ? mt.hit_idx : mt.free_idx;
    found = mt.hit || mt.free_ok;
    bad   = (req_i.key == '0) || (req_i.mode == 2'd3);
    wh    = wh_q[sel];
    rh    = rh_q[sel];
    rc    = rc_q[sel];
    wc    = wc_q[sel];
    wh_d  = wh;
    rh_d  = rh;
    rc_d  = rc;
    wc_d  = wc;
    busy  = 1'b0;
    unique case (req_i.mode)
      MODE_READ: begin
        busy = wh || (rc == COUNT_MAX);
        if (!busy) begin
          rc_d = count_t'(rc + 1'b1);
          rh_d = 1'b1;
        end
      end
      MODE_WRITE: begin
        busy = wh || rh || (wc == COUNT_MAX);
        if (!busy) begin
          wc_d = count_t'(wc + 1'b1);
          wh_d = 1'b1;
        end
      end
      MODE_UNLOCK: begin
        if (wh) begin
          wh_d = 1'b0;
          if (wc != '0) wc_d = count_t'(wc - 1'b1);
        end else if (rh) begin
          if (rc != '0) rc_d = count_t'(rc - 1'b1);
          if (rc_d == '0) rh_d = 1'b0;
        end
      end
      default: busy = 1'b1;
    endcase
    // an entry with no holders goes back to free
    used  = (wc_d != '0) || (rc_d != '0);
    key_d = used ? req_i.key : '0;
    if (!used) begin
      wh_d = 1'b0;
      rh_d = 1'b0;
    end
    we = upd_i && !bad && found;

    rsp_o.still_used = 1'b0;
    if (bad) begin
      rsp_o.status = ST_BUSY;
    end else if (!found) begin
      rsp_o.status = ST_FULL;
    end else if (busy) begin
      rsp_o.status = ST_BUSY;
    end else begin
      rsp_o.status = ST_DONE;
      rsp_o.still_used = (req_i.mode == MODE_UNLOCK) && used;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        key_q[i] <= '0;
        wh_q[i]  <= 1'b0;
        rh_q[i]  <= 1'b0;
        rc_q[i]  <= '0;
        wc_q[i]  <= '0;
      end
    end else if (we) begin
      key_q[sel] <= key_d;
      wh_q[sel]  <= wh_d;
      rh_q[sel]  <= rh_d;
      rc_q[sel]  <= rc_d;
      wc_q[sel]  <= wc_d;
    end
  end

endmodule

### rtl/keyed_reader_writer_lock_table.sv
// top level of the keyed reader/writer lock table
// usage:
//   req_i carries one word per request: mode (read try, write try, unlock)
//   and a nonzero 48 bit key. rsp_o returns one word per request: status
//   (done, busy, table full) and still_used, set after an unlock that leaves
//   the key with readers or a writer.
//   both channels move a word on a clock edge with valid and ready high.
//   a request is captured in an input register; from there its key is matched
//   against all 16 entries at once, the one selected entry is updated and
//   the response register is loaded. one request is taken every cycle while
//   the response register is empty or its word is being taken.
//   the table is read and written by the same stage, so back to back
//   requests on one key always see each other's effect.
//   when the receiver stalls, the response register holds its word and the
//   input register keeps the waiting request; req_i.ready drops once both
//   are full and rises again as soon as the response is taken.
//   reset clears the whole table (all entries free) and the valid flags of both registers.
module keyed_reader_writer_lock_table import krwl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  krwl_req_if.sink   req_i,
  krwl_rsp_if.source rsp_o
);

  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  rsp_t out_q;
  rsp_t rsp;
  logic adv;

  assign adv         = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || adv;

  krwl_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv),
    .req_i  (in_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.mode <= req_i.mode;
      in_q.key  <= req_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= rsp;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.still_used = out_q.still_used;

  a_adv_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> rsp_o.valid)
    else $error("processed request produced no response word");

  a_pending_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> (in_valid_q && $stable(in_q)))
    else $error("waiting request lost or changed");

  a_still_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.still_used) |-> (rsp_o.status == ST_DONE))
    else $error("still_used set on a refused request");

endmodule
